/* design/rcf_pkg.sv */
// Shared types, codes and the CRC-32 byte update for the response framer.
// No dependencies; imported by every module of the framer.
package rcf_pkg;

  localparam int BLOCK_SIZE = 256;
  localparam logic [15:0] LONG_LIMIT = 16'(BLOCK_SIZE + 7);
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_RAW   = 2'd2;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_STRAY = 2'd1;
  localparam logic [1:0] ERR_LONG  = 2'd2;
  localparam logic [1:0] ERR_OPEN  = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  response_code;
    logic [15:0] payload_length;
    logic        allow_long;
    logic [7:0]  data_byte;
    logic        raw_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
    logic [1:0] error_code;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_ERR,
    OP_START,
    OP_DATA,
    OP_RAW
  } job_op_t;

  // One classified item: everything the back end needs to emit its beats.
  typedef struct packed {
    job_op_t     op;
    logic [1:0]  err;
    logic [7:0]  hdr0;
    logic [7:0]  hdr1;
    logic [7:0]  dbyte;
    logic        with_crc;
    logic        raw_last;
    logic [31:0] crc;
  } job_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* design/rcf_front.sv */
// Front end: accepts items, checks misuse, keeps frame state and the running CRC.
// Pushes one job with results per defined item into the job queue. Uses rcf_pkg.
module rcf_front import rcf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     push,
  output job_t     push_job
);

  logic        frame_open_r, frame_open_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [31:0] crc_r, crc_nxt;

  logic        accept;
  logic [15:0] wire_len;
  logic [15:0] bytes_dec;
  logic [31:0] crc_code;
  logic [31:0] crc_data;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign wire_len  = 16'(in_data.payload_length + 16'd1);
  assign bytes_dec = 16'(bytes_left_r - 16'd1);
  assign crc_code  = crc_byte(CRC_INIT, in_data.response_code);
  assign crc_data  = crc_byte(crc_r, in_data.data_byte);

  always_comb begin
    frame_open_nxt = frame_open_r;
    bytes_left_nxt = bytes_left_r;
    crc_nxt        = crc_r;
    push           = 1'b0;
    push_job       = '{op: OP_ERR, err: ERR_NONE, hdr0: wire_len[15:8], hdr1: wire_len[7:0],
                       dbyte: in_data.data_byte, with_crc: 1'b0,
                       raw_last: in_data.raw_last, crc: ~crc_data};
    if (accept) begin
      unique case (in_data.kind)
        KIND_START: begin
          push = 1'b1;
          if (frame_open_r) begin
            push_job.err = ERR_OPEN;
          end else if (in_data.payload_length > LONG_LIMIT && !in_data.allow_long) begin
            push_job.err = ERR_LONG;
          end else begin
            push_job.op    = OP_START;
            push_job.dbyte = in_data.response_code;
            push_job.crc   = ~crc_code;
            if (in_data.payload_length == 16'd0) begin
              push_job.with_crc = 1'b1;
            end else begin
              frame_open_nxt = 1'b1;
              bytes_left_nxt = in_data.payload_length;
              crc_nxt        = crc_code;
            end
          end
        end
        KIND_DATA: begin
          push = 1'b1;
          if (!frame_open_r) begin
            push_job.err = ERR_STRAY;
          end else begin
            push_job.op    = OP_DATA;
            bytes_left_nxt = bytes_dec;
            crc_nxt        = crc_data;
            if (bytes_dec == 16'd0) begin
              push_job.with_crc = 1'b1;
              frame_open_nxt    = 1'b0;
              crc_nxt           = CRC_INIT;
            end
          end
        end
        KIND_RAW: begin
          push        = 1'b1;
          push_job.op = OP_RAW;
        end
        default: begin
          // undefined kind: dropped, no beats
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r <= 1'b0;
      bytes_left_r <= 16'd0;
      crc_r        <= CRC_INIT;
    end else begin
      frame_open_r <= frame_open_nxt;
      bytes_left_r <= bytes_left_nxt;
      crc_r        <= crc_nxt;
    end
  end

endmodule

/* design/rcf_fifo.sv */
// Short job queue between the front and back ends.
// Register array with read/write pointers and a fill count. Uses rcf_pkg.
module rcf_fifo import rcf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output job_t head_job
);

  job_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0] count_r;
  logic               do_push, do_pop;

  assign full       = (count_r == FIFO_CW'(FIFO_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= FIFO_AW'(wr_ptr_r + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_r <= FIFO_AW'(rd_ptr_r + 1'b1);
      end
      if (do_push && !do_pop) begin
        count_r <= FIFO_CW'(count_r + 1'b1);
      end else if (do_pop && !do_push) begin
        count_r <= FIFO_CW'(count_r - 1'b1);
      end
    end
  end

endmodule

/* design/rcf_back.sv */
// Back end: expands the head job into output beats, one per cycle unless out is
// stalled, into an output register. Pops the job on its last beat. Uses rcf_pkg.
module rcf_back import rcf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  job_t      head_job,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic [2:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_r, out_nxt;

  logic       load;
  logic [2:0] last_idx;
  logic [2:0] hdr_cnt;
  logic [2:0] crc_idx;
  logic       is_last;
  logic [7:0] beat_byte;

  assign load    = head_valid && (!out_valid_r || out_ready);
  assign hdr_cnt = (head_job.op == OP_START) ? 3'd3 : 3'd1;
  assign crc_idx = 3'(idx_r - hdr_cnt);
  assign is_last = (idx_r == last_idx);
  assign pop     = load && is_last;

  always_comb begin
    unique case (head_job.op)
      OP_START: last_idx = head_job.with_crc ? 3'd6 : 3'd2;
      OP_DATA:  last_idx = head_job.with_crc ? 3'd4 : 3'd0;
      default:  last_idx = 3'd0;
    endcase
  end

  always_comb begin
    if (idx_r < hdr_cnt) begin
      unique case (idx_r[1:0])
        2'd0:    beat_byte = (head_job.op == OP_START) ? head_job.hdr0 : head_job.dbyte;
        2'd1:    beat_byte = head_job.hdr1;
        default: beat_byte = head_job.dbyte;
      endcase
    end else begin
      // CRC goes out most significant byte first
      unique case (crc_idx[1:0])
        2'd0:    beat_byte = head_job.crc[31:24];
        2'd1:    beat_byte = head_job.crc[23:16];
        2'd2:    beat_byte = head_job.crc[15:8];
        default: beat_byte = head_job.crc[7:0];
      endcase
    end
  end

  always_comb begin
    idx_nxt       = idx_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (load) begin
      out_valid_nxt    = 1'b1;
      idx_nxt          = is_last ? 3'd0 : 3'(idx_r + 3'd1);
      out_nxt.run_last = is_last;
      unique case (head_job.op)
        OP_ERR: begin
          out_nxt.out_byte   = 8'd0;
          out_nxt.frame_end  = 1'b0;
          out_nxt.error_code = head_job.err;
        end
        OP_RAW: begin
          out_nxt.out_byte   = head_job.dbyte;
          out_nxt.frame_end  = head_job.raw_last;
          out_nxt.error_code = ERR_NONE;
        end
        default: begin
          out_nxt.out_byte   = beat_byte;
          out_nxt.frame_end  = head_job.with_crc && is_last;
          out_nxt.error_code = ERR_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* design/crc32_response_framer_core.sv */
// Top level of the CRC-32 response framer: front end, job queue, back end.
// Depends on rcf_pkg, rcf_front, rcf_fifo and rcf_back.
//
//   channel | dir | ports                         | beat
//   in      | in  | in_valid, in_ready, in_data   | one item (in_item_t)
//   out     | out | out_valid, out_ready, out_data| one wire byte (out_item_t)
//
// Items are taken one per cycle while the 4-entry job queue has room.
// The back end sends one beat per cycle while out_ready is high: 1 for payload,
// raw and error items, 3 for a start, plus 4 CRC beats at the end of a frame
// (7 for an empty one). Sustained rate is one item per cycle in the payload
// phase; header and CRC bursts are absorbed by the queue, then in_ready drops.
// Reset (rst_n low, synchronous) closes any frame, empties the queue and
// the output register. Either side may stall without losing beats.
module crc32_response_framer_core import rcf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic q_full, push, pop, head_valid;
  job_t push_job, head_job;

  rcf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  rcf_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  rcf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

/* design/rcf_checker.sv */
// Port-level checks for the response framer, bound to the top level.
// Depends on rcf_pkg and crc32_response_framer_core.
module rcf_checker import rcf_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // a stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("out beat changed while stalled");

  // error beats stand alone: zero byte, last of the item, not a frame end
  a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error_code != ERR_NONE |->
      out_data.run_last && !out_data.frame_end && out_data.out_byte == 8'd0)
    else $error("malformed error beat");

  // a frame end is always the last beat of its item
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_end |-> out_data.run_last)
    else $error("frame end before last beat of item");

  // reset empties the output register
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid set right after reset");

endmodule

bind crc32_response_framer_core rcf_checker u_rcf_checker (.*);

/* test/tb_crc32_response_framer_core.sv */
// Testbench for crc32_response_framer_core: directed and random items checked beat by beat
// against a frame predictor, with bursty sender and stalling receiver.
// Depends on rcf_pkg (types and codes) and the framer RTL.
module tb_crc32_response_framer_core;
  import rcf_pkg::*;

  localparam int RANDOM_ITEMS = 225;
  localparam int LEN_LIMIT = BLOCK_SIZE + 7;
  localparam logic [31:0] CRC_REFLECTED_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_SEED = 32'hFFFF_FFFF;
  localparam logic [1:0] KIND_UNDEF = 2'd3;
  localparam int MAX_FRAME_LEN = 65535;
  localparam int TAIL_BYTES = 12;
  // ~600 items at most; worst case per item is the longest sender gap plus 7 stalled beats
  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int DRAIN_CYCLES = 16;

  typedef struct packed {
    logic     wait_idle;
    in_item_t item;
  } pending_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  pending_t    pending_items[$];
  out_item_t   expected_beats[$];
  int          fail_count = 0;
  int          stim_count = 0;
  int unsigned cycle_count = 0;

  // predictor state
  logic        frame_active = 1'b0;
  logic [15:0] payload_left = '0;
  logic [31:0] crc_state = CRC_SEED;

  // sender / receiver pacing
  int   burst_left = 0;
  int   gap_left = 0;
  int   stall_left = 0;
  int   mode_left = 0;
  logic stall_mode = 1'b0;

  out_item_t want;

  crc32_response_framer_core dut (
    .clk,
    .rst_n,
    .in_valid,
    .in_ready,
    .in_data,
    .out_valid,
    .out_ready,
    .out_data
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [31:0] crc32_shift_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] r;
    r = crc ^ {24'd0, b};
    repeat (8) r = (r >> 1) ^ (CRC_REFLECTED_POLY & {32{r[0]}});
    return r;
  endfunction

  function automatic out_item_t wire_beat(input logic [7:0] b, input logic fend,
                                          input logic [1:0] err);
    out_item_t r;
    r.out_byte = b;
    r.run_last = 1'b0;
    r.frame_end = fend;
    r.error_code = err;
    return r;
  endfunction

  // Works out the beats one accepted item causes and queues them.
  task automatic predict_beats(input in_item_t it);
    out_item_t   beats[7];
    out_item_t   b;
    int          n;
    logic        add_tail;
    logic [31:0] tail_crc;
    logic [15:0] wire_len;
    n = 0;
    add_tail = 1'b0;
    tail_crc = '0;
    case (it.kind)
      KIND_START: begin
        if (frame_active) begin
          beats[n] = wire_beat(8'h00, 1'b0, ERR_OPEN);
          n++;
        end else if (it.payload_length > LEN_LIMIT && !it.allow_long) begin
          beats[n] = wire_beat(8'h00, 1'b0, ERR_LONG);
          n++;
        end else begin
          wire_len = it.payload_length + 16'd1;
          beats[0] = wire_beat(wire_len[15:8], 1'b0, ERR_NONE);
          beats[1] = wire_beat(wire_len[7:0], 1'b0, ERR_NONE);
          beats[2] = wire_beat(it.response_code, 1'b0, ERR_NONE);
          n = 3;
          if (it.payload_length == 16'd0) begin
            add_tail = 1'b1;
            tail_crc = crc32_shift_byte(CRC_SEED, it.response_code);
            crc_state = CRC_SEED;
          end else begin
            frame_active = 1'b1;
            payload_left = it.payload_length;
            crc_state = crc32_shift_byte(CRC_SEED, it.response_code);
          end
        end
      end
      KIND_DATA: begin
        if (!frame_active) begin
          beats[n] = wire_beat(8'h00, 1'b0, ERR_STRAY);
          n++;
        end else begin
          beats[n] = wire_beat(it.data_byte, 1'b0, ERR_NONE);
          n++;
          crc_state = crc32_shift_byte(crc_state, it.data_byte);
          payload_left = payload_left - 16'd1;
          if (payload_left == 16'd0) begin
            add_tail = 1'b1;
            tail_crc = crc_state;
            frame_active = 1'b0;
            crc_state = CRC_SEED;
          end
        end
      end
      KIND_RAW: begin
        beats[n] = wire_beat(it.data_byte, it.raw_last, ERR_NONE);
        n++;
      end
      default: ;
    endcase
    if (add_tail) begin
      tail_crc = ~tail_crc;
      for (int k = 3; k >= 0; k--) begin
        beats[n] = wire_beat(tail_crc[8*k +: 8], k == 0, ERR_NONE);
        n++;
      end
    end
    for (int i = 0; i < n; i++) begin
      b = beats[i];
      b.run_last = (i == n - 1);
      expected_beats.push_back(b);
    end
  endtask

  task automatic check_field(input string field, input int unsigned exp_val,
                             input int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, exp_val, act_val);
      fail_count++;
    end
  endtask

  function automatic in_item_t noise_item();
    in_item_t it;
    it.kind = 2'($urandom);
    it.response_code = 8'($urandom);
    it.payload_length = 16'($urandom);
    it.allow_long = 1'($urandom);
    it.data_byte = 8'($urandom);
    it.raw_last = 1'($urandom);
    return it;
  endfunction

  task automatic push_item(input in_item_t it, input logic wait_idle);
    pending_t p;
    p.wait_idle = wait_idle;
    p.item = it;
    pending_items.push_back(p);
    if (it.kind != KIND_UNDEF) stim_count++;
  endtask

  task automatic push_start(input logic [7:0] code, input logic [15:0] len, input logic allow,
                            input logic wait_idle);
    in_item_t it;
    it = noise_item();
    it.kind = KIND_START;
    it.response_code = code;
    it.payload_length = len;
    it.allow_long = allow;
    push_item(it, wait_idle);
  endtask

  task automatic push_payload(input logic [7:0] b);
    in_item_t it;
    it = noise_item();
    it.kind = KIND_DATA;
    it.data_byte = b;
    push_item(it, 1'b0);
  endtask

  task automatic push_raw(input logic [7:0] b, input logic last);
    in_item_t it;
    it = noise_item();
    it.kind = KIND_RAW;
    it.data_byte = b;
    it.raw_last = last;
    push_item(it, 1'b0);
  endtask

  task automatic push_undefined();
    in_item_t it;
    it = noise_item();
    it.kind = KIND_UNDEF;
    push_item(it, 1'b0);
  endtask

  // Driver: bursts of random length, random gaps, holds payload until accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) predict_beats(in_data);
      if (in_valid && !in_ready) begin
        // hold the beat
      end else if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_items.size() == 0 ||
                   (pending_items[0].wait_idle && expected_beats.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_data <= pending_items[0].item;
        pending_items.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 16);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Receiver: alternates between stretches with no stalls and stretches with random stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
      mode_left <= 0;
      stall_mode <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode_left <= $urandom_range(50, 300);
        stall_mode <= ($urandom_range(0, 2) != 0);
      end else begin
        mode_left <= mode_left - 1;
      end
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (stall_mode && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        stall_left <= $urandom_range(0, 4);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        $error("beat with nothing expected: out_byte 0x%0h error_code %0d",
               out_data.out_byte, out_data.error_code);
        fail_count++;
      end else begin
        want = expected_beats.pop_front();
        check_field("out_byte", want.out_byte, out_data.out_byte);
        check_field("run_last", want.run_last, out_data.run_last);
        check_field("frame_end", want.frame_end, out_data.frame_end);
        check_field("error_code", want.error_code, out_data.error_code);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int   stim_goal;
    int   pick;
    int   sel;
    int   len;
    int   n_bytes;
    logic allow;

    // directed part
    push_payload(8'hFF);                          // stray byte, nothing open
    push_start(8'h00, 16'd0, 1'b0, 1'b0);         // empty frame: header and CRC only
    push_start(8'hFF, 16'd0, 1'b1, 1'b0);
    push_start(8'h3C, 16'(LEN_LIMIT + 1), 1'b0, 1'b0); // just past the long limit
    push_start(8'hC3, 16'hFFFF, 1'b0, 1'b0);
    push_start(8'hA5, 16'd3, 1'b0, 1'b0);
    push_start(8'h11, 16'd0, 1'b1, 1'b0);         // start while open
    push_raw(8'h5A, 1'b1);                        // raw beat inside a frame
    push_payload(8'h00);
    push_undefined();
    push_payload(8'h80);
    push_payload(8'hFF);
    push_raw(8'h00, 1'b0);
    push_raw(8'hFF, 1'b1);
    push_start(8'h12, 16'd1, 1'b1, 1'b1);
    push_payload(8'h34);
    push_undefined();

    // random part: mostly complete frames, some raw responses and misuse
    stim_goal = stim_count + RANDOM_ITEMS;
    while (stim_count < stim_goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        sel = $urandom_range(0, 49);
        if (sel == 0) len = $urandom_range(200, 300);
        else if (sel == 1) len = LEN_LIMIT + $urandom_range(0, 1);
        else len = $urandom_range(0, 12);
        allow = (len > LEN_LIMIT) ? ($urandom_range(0, 3) != 0) : 1'($urandom);
        push_start(8'($urandom), 16'(len), allow, $urandom_range(0, 19) == 0);
        if (len <= LEN_LIMIT || allow) begin
          for (int i = 0; i < len; i++) begin
            sel = $urandom_range(0, 29);
            if (sel == 0) push_raw(8'($urandom), 1'($urandom));
            else if (sel == 1) push_undefined();
            else if (sel == 2) push_start(8'($urandom), 16'($urandom_range(0, 12)),
                                          1'($urandom), 1'b0);
            push_payload(8'($urandom));
          end
        end
      end else if (pick < 82) begin
        n_bytes = $urandom_range(1, 6);
        for (int i = 0; i < n_bytes; i++) push_raw(8'($urandom), 1'(i == n_bytes - 1));
      end else begin
        sel = $urandom_range(0, 2);
        if (sel == 0) push_payload(8'($urandom));
        else if (sel == 1) push_start(8'($urandom),
                                      16'($urandom_range(LEN_LIMIT + 1, MAX_FRAME_LEN)),
                                      1'b0, 1'b0);
        else push_undefined();
      end
    end

    // length field wraps: header reads 0x0000 and the frame stays open for 65535
    // payload bytes; only the first few are sent
    push_start(8'($urandom), 16'hFFFF, 1'b1, 1'b1);
    for (int i = 0; i < TAIL_BYTES; i++) begin
      if (i == 5) push_start(8'($urandom), 16'd2, 1'b0, 1'b0);
      if (i == 7) push_raw(8'($urandom), 1'($urandom));
      push_payload(8'($urandom));
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_valid) @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
